FILE: hw/rtl/torq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package torq_pkg;

    // Slot table geometry
    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam logic [PTR_W-1:0] NO_NEXT = PTR_W'(SLOTS);

    // Action codes
    localparam logic [2:0] ACT_SCHED      = 3'd0;
    localparam logic [2:0] ACT_REM_THREAD = 3'd1;
    localparam logic [2:0] ACT_RESCHED    = 3'd2;
    localparam logic [2:0] ACT_REM_PROC   = 3'd3;
    localparam logic [2:0] ACT_QUERY_PROC = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] thread_id;
        logic [31:0] process_id;
        logic [63:0] timestamp;
        logic        wake_head;
    } t_in_req;

    typedef struct packed {
        logic        found;
        logic [31:0] removed_thread;
        logic        wake_valid;
        logic [31:0] wake_thread;
        logic        head_valid;
        logic [31:0] head_thread;
        logic [6:0]  queue_size;
        logic [1:0]  status;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_ALLOC,
        S_UL_START,
        S_UL_WALK,
        S_WAKE_RD,
        S_WAKE,
        S_INS_START,
        S_INS_WALK,
        S_INS_LINK1,
        S_INS_LINK2,
        S_FIN_RD,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_HEAD,
        CUR_LINK
    } t_cur_sel;

    typedef enum logic [1:0] {
        PREV_HOLD,
        PREV_NONE,
        PREV_CUR
    } t_prev_sel;

    typedef struct packed {
        logic      load_in;
        t_cur_sel  cur_sel;
        t_prev_sel prev_sel;
        logic      set_slot;
        logic      alloc;
        logic      set_full;
        logic      set_dup;
        logic      set_found;
        logic      unlink;
        logic      wake_cap;
        logic      ins_mark;
        logic      link_slot;
        logic      link_prev;
        logic      load_out;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       cur_end;
        logic       ft_end;
        logic       ft_hit;
        logic       slot_queued;
        logic       full;
        logic       ul_hit;
        logic       in_stop;
        logic       prev_none;
        logic       out_busy;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/torq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [2:0]    i_in_action,
    input  wire torq_pkg::t_sts i_sts,
    output torq_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);
    import torq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_action)
                        ACT_SCHED, ACT_REM_THREAD, ACT_RESCHED: n_state = S_FIND;
                        ACT_REM_PROC, ACT_QUERY_PROC:           n_state = S_UL_WALK;
                        default:                                n_state = S_FIN_RD;
                    endcase
                end
            end
            S_FIND: begin
                if (i_sts.ft_end) begin
                    n_state = (i_sts.act == ACT_REM_THREAD) ? S_FIN_RD : S_ALLOC;
                end else if (i_sts.ft_hit) begin
                    if (i_sts.act == ACT_REM_THREAD) begin
                        n_state = i_sts.slot_queued ? S_UL_START : S_FIN_RD;
                    end else if (i_sts.act == ACT_SCHED) begin
                        n_state = i_sts.slot_queued ? S_FIN_RD : S_INS_START;
                    end else begin
                        n_state = i_sts.slot_queued ? S_UL_START : S_INS_START;
                    end
                end
            end
            S_ALLOC:    n_state = i_sts.full ? S_FIN_RD : S_INS_START;
            S_UL_START: n_state = S_UL_WALK;
            S_UL_WALK: begin
                if (i_sts.cur_end) begin
                    n_state = S_FIN_RD;
                end else if (i_sts.ul_hit) begin
                    if (i_sts.act == ACT_RESCHED) begin
                        n_state = i_sts.prev_none ? S_WAKE_RD : S_INS_START;
                    end else begin
                        n_state = S_FIN_RD;
                    end
                end
            end
            S_WAKE_RD:   n_state = S_WAKE;
            S_WAKE:      n_state = S_INS_START;
            S_INS_START: n_state = S_INS_WALK;
            S_INS_WALK:  n_state = i_sts.in_stop ? S_INS_LINK1 : S_INS_WALK;
            S_INS_LINK1: n_state = S_INS_LINK2;
            S_INS_LINK2: n_state = S_FIN_RD;
            S_FIN_RD:    n_state = S_FIN;
            S_FIN:       n_state = i_sts.out_busy ? S_FIN : S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.cur_sel  = CUR_HOLD;
        o_cmd.prev_sel = PREV_HOLD;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in  = 1'b1;
                    o_cmd.prev_sel = PREV_NONE;
                    case (i_in_action)
                        ACT_REM_PROC, ACT_QUERY_PROC: o_cmd.cur_sel = CUR_HEAD;
                        default:                      o_cmd.cur_sel = CUR_ZERO;
                    endcase
                end
            end
            S_FIND: begin
                if (!i_sts.ft_end && i_sts.ft_hit) begin
                    o_cmd.set_slot = 1'b1;
                    if (i_sts.act == ACT_SCHED && i_sts.slot_queued) begin
                        o_cmd.set_dup = 1'b1;
                    end
                end else if (!i_sts.ft_end) begin
                    o_cmd.cur_sel = CUR_INC;
                end
            end
            S_ALLOC: begin
                if (i_sts.full) begin
                    o_cmd.set_full = 1'b1;
                end else begin
                    o_cmd.alloc = 1'b1;
                end
            end
            S_UL_START: begin
                o_cmd.cur_sel  = CUR_HEAD;
                o_cmd.prev_sel = PREV_NONE;
            end
            S_UL_WALK: begin
                if (!i_sts.cur_end) begin
                    if (i_sts.ul_hit) begin
                        if (i_sts.act == ACT_QUERY_PROC) begin
                            o_cmd.set_found = 1'b1;
                        end else begin
                            o_cmd.unlink = 1'b1;
                        end
                    end else begin
                        o_cmd.prev_sel = PREV_CUR;
                        o_cmd.cur_sel  = CUR_LINK;
                    end
                end
            end
            S_WAKE_RD: o_cmd.cur_sel = CUR_HEAD;
            S_WAKE:    o_cmd.wake_cap = 1'b1;
            S_INS_START: begin
                o_cmd.ins_mark = 1'b1;
                o_cmd.cur_sel  = CUR_HEAD;
                o_cmd.prev_sel = PREV_NONE;
            end
            S_INS_WALK: begin
                if (!i_sts.in_stop) begin
                    o_cmd.prev_sel = PREV_CUR;
                    o_cmd.cur_sel  = CUR_LINK;
                end
            end
            S_INS_LINK1: o_cmd.link_slot = 1'b1;
            S_INS_LINK2: o_cmd.link_prev = 1'b1;
            S_FIN_RD:    o_cmd.cur_sel = CUR_HEAD;
            S_FIN:       o_cmd.load_out = !i_sts.out_busy;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/torq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire torq_pkg::t_in_req i_in_data,
    input  wire torq_pkg::t_cmd    i_cmd,
    output torq_pkg::t_sts         o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output torq_pkg::t_out_req     o_out_data
);
    import torq_pkg::*;

    // Slot table memories
    logic [31:0]      m_thread [SLOTS];
    logic [31:0]      m_proc   [SLOTS];
    logic [63:0]      m_time   [SLOTS];
    logic [PTR_W-1:0] m_link   [SLOTS];

    logic [31:0]      rd_thread;
    logic [31:0]      rd_proc;
    logic [63:0]      rd_time;
    logic [PTR_W-1:0] rd_link;

    logic [SLOTS-1:0]  r_queued;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_used;
    logic [PTR_W-1:0]  r_count;
    logic [PTR_W-1:0]  r_cur;
    logic [PTR_W-1:0]  n_cur;
    logic [PTR_W-1:0]  r_prev;
    logic [SLOT_W-1:0] r_slot;
    t_in_req           r_req;

    logic        r_found;
    logic [31:0] r_removed;
    logic        r_wv;
    logic [31:0] r_wt;
    logic [1:0]  r_status;
    logic        r_out_valid;
    t_out_req    r_out;

    logic             lk_we;
    logic [SLOT_W-1:0] lk_addr;
    logic [PTR_W-1:0] lk_data;
    logic             prev_none;
    logic             head_ok;
    logic             proc_act;

    assign prev_none = (r_prev == NO_NEXT);
    assign head_ok   = (r_head != NO_NEXT);
    assign proc_act  = (r_req.action == ACT_REM_PROC) || (r_req.action == ACT_QUERY_PROC);

    // Walk pointer; memories are read at its next value
    always_comb begin
        case (i_cmd.cur_sel)
            CUR_ZERO: n_cur = '0;
            CUR_INC:  n_cur = r_cur + 1'b1;
            CUR_HEAD: n_cur = r_head;
            CUR_LINK: n_cur = rd_link;
            default:  n_cur = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        rd_thread <= m_thread[n_cur[SLOT_W-1:0]];
        rd_proc   <= m_proc[n_cur[SLOT_W-1:0]];
        rd_time   <= m_time[n_cur[SLOT_W-1:0]];
        rd_link   <= m_link[n_cur[SLOT_W-1:0]];
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            m_thread[r_used[SLOT_W-1:0]] <= r_req.thread_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_mark) begin
            m_proc[r_slot] <= r_req.process_id;
            m_time[r_slot] <= r_req.timestamp;
        end
    end

    // Link port: bypass on unlink, forward link on insert, back link on insert
    always_comb begin
        lk_we   = 1'b0;
        lk_addr = r_prev[SLOT_W-1:0];
        lk_data = rd_link;
        if (i_cmd.unlink && !prev_none) begin
            lk_we = 1'b1;
        end else if (i_cmd.link_slot) begin
            lk_we   = 1'b1;
            lk_addr = r_slot;
            lk_data = r_cur;
        end else if (i_cmd.link_prev && !prev_none) begin
            lk_we   = 1'b1;
            lk_data = PTR_W'(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            m_link[lk_addr] <= lk_data;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
            r_head   <= NO_NEXT;
            r_used   <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.alloc) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.unlink) begin
                r_queued[r_cur[SLOT_W-1:0]] <= 1'b0;
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
                if (prev_none) begin
                    r_head <= rd_link;
                end
            end
            if (i_cmd.ins_mark) begin
                r_queued[r_slot] <= 1'b1;
            end
            if (i_cmd.link_prev) begin
                r_count <= r_count + 1'b1;
                if (prev_none) begin
                    r_head <= PTR_W'(r_slot);
                end
            end
        end
    end

    // Request latch, walk registers and result fields
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        case (i_cmd.prev_sel)
            PREV_NONE: r_prev <= NO_NEXT;
            PREV_CUR:  r_prev <= r_cur;
            default:   r_prev <= r_prev;
        endcase
        if (i_cmd.set_slot) begin
            r_slot <= r_cur[SLOT_W-1:0];
        end
        if (i_cmd.alloc) begin
            r_slot <= r_used[SLOT_W-1:0];
        end
        if (i_cmd.load_in) begin
            r_req     <= i_in_data;
            r_found   <= 1'b0;
            r_removed <= '0;
            r_wv      <= 1'b0;
            r_wt      <= '0;
            r_status  <= ST_OK;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.set_dup) begin
            r_status <= ST_DUP;
            r_found  <= 1'b1;
        end
        if (i_cmd.set_found) begin
            r_found <= 1'b1;
        end
        if (i_cmd.unlink) begin
            r_found   <= 1'b1;
            r_removed <= (r_req.action == ACT_REM_PROC) ? rd_thread : r_req.thread_id;
        end
        if (i_cmd.wake_cap && head_ok) begin
            r_wv <= 1'b1;
            r_wt <= rd_thread;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.found          <= r_found;
            r_out.removed_thread <= r_removed;
            r_out.head_valid     <= head_ok;
            r_out.head_thread    <= head_ok ? rd_thread : '0;
            r_out.queue_size     <= 7'(r_count);
            r_out.status         <= r_status;
            if (r_req.action == ACT_REM_THREAD && r_req.wake_head && head_ok) begin
                r_out.wake_valid  <= 1'b1;
                r_out.wake_thread <= rd_thread;
            end else begin
                r_out.wake_valid  <= r_wv;
                r_out.wake_thread <= r_wt;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status to controller
    always_comb begin
        o_sts.act         = r_req.action;
        o_sts.cur_end     = (r_cur >= NO_NEXT);
        o_sts.ft_end      = (r_cur >= r_used);
        o_sts.ft_hit      = (rd_thread == r_req.thread_id);
        o_sts.slot_queued = r_queued[r_cur[SLOT_W-1:0]];
        o_sts.full        = (r_used >= NO_NEXT);
        o_sts.ul_hit      = proc_act ? (rd_proc == r_req.process_id)
                                     : (r_cur == PTR_W'(r_slot));
        o_sts.in_stop     = (r_cur >= NO_NEXT) || (rd_time > r_req.timestamp);
        o_sts.prev_none   = prev_none;
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/timestamp_ordered_run_queue.sv
// Timestamp-ordered run queue of up to SLOTS threads.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
// schedule, remove by thread, reschedule, remove by process or query process.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
// result per request: found flag, removed thread, wake hint, head, size, status.
// Requests are handled one at a time. The controller walks the slot table and
// the linked list one entry per cycle through registered memory reads:
//   a thread lookup over the used slots, a list walk to unlink or match,
//   and an insertion walk ordered by timestamp, plus setup and finish states.
// The result sits in an output register; the next request is accepted while
// it waits, and only the following result stalls if the receiver holds off.
// Reset (synchronous, active low) empties the queue and frees all slots;
// slot contents are written before they are ever used.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_ordered_run_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire torq_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output torq_pkg::t_out_req      o_out_data
);
    import torq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    torq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready)
    );

    // Slot table, list pointers and result register
    torq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/torq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module torq_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire torq_pkg::t_in_req  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire torq_pkg::t_out_req o_out_data
);
    import torq_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Head flag agrees with queue size
    a_head_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.head_valid == (o_out_data.queue_size != 7'd0)))
        else $error("head flag and size disagree");

    // Nothing removed without a match
    a_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.removed_thread == 32'd0)
        else $error("removed thread without match");

    // Error status carries no wake hint and no removal
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK)
            |-> !o_out_data.wake_valid && (o_out_data.removed_thread == 32'd0))
        else $error("error status with side effects");

endmodule

bind timestamp_ordered_run_queue torq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
